@@ rtl/dual_slope_adc_sequencer_unit_macros.svh @@
// assertion macros for the dual-slope adc sequencer
// used by the top level only; no other dependencies
`ifndef DUAL_SLOPE_ADC_SEQUENCER_UNIT_MACROS_SVH
`define DUAL_SLOPE_ADC_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DSAS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define DSAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSAS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define DSAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/dsas_pkg.sv @@
// shared types and constants for the dual-slope adc sequencer
// no dependencies; imported by dsas_div and the top level
package dsas_pkg;

    localparam int DATA_W     = 32;
    localparam int REG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_BITS = 16;
    localparam int RAW_W      = 16;
    localparam int MV_W       = 14;
    localparam int PROD_W     = 2 * DATA_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [DATA_W-1:0] SCALE_DIV  = DATA_W'(1000000);
    localparam logic [DATA_W-1:0] GAIN_RESET = DATA_W'(2400 / 20 * 1000);

    // x / 1000000 = ((x >> 6) * RECIP_M) >> RECIP_SHIFT, exact for any 32-bit x
    // RECIP_M = ceil(2^40 / 15625); its error times 2^26 stays below 2^40
    localparam int RECIP_PRE   = 6;
    localparam int RECIP_SHIFT = 40;
    localparam logic [DATA_W-1:0] RECIP_M = DATA_W'(70368745);

    localparam logic [REG_W-1:0] FEEDBACK_RESET  = REG_W'(50000);
    localparam logic [REG_W-1:0] SETUP_RESET     = REG_W'(3000);
    localparam logic [REG_W-1:0] INTEGRATE_RESET = REG_W'(20000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATE = 2'd2;

    // request modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_MEAS = 2'd1;
    localparam logic [1:0] MODE_ZERO = 2'd2;
    localparam logic [1:0] MODE_GAIN = 2'd3;

    // conversion kinds
    localparam logic [1:0] KIND_MEAS = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_GAIN = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BUSY     = 2'd1;
    localparam logic [1:0] STAT_DIV_ZERO = 2'd2;
    localparam logic [1:0] STAT_OVER     = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/dsas_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on dsas_pkg
module dsas_div import dsas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output t_div_stat         o_stat,
    output logic [DATA_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DATA_W:0]   w_trial;
    logic              w_ge;
    logic [DATA_W-1:0] n_rem;

    assign w_trial = {r_rem, r_quo[DATA_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign n_rem   = w_ge ? DATA_W'(w_trial - {1'b0, r_den}) : w_trial[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_den  <= i_divisor;
            r_step <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= {r_quo[DATA_W-2:0], w_ge};
            r_step <= r_step + 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

@@ rtl/dual_slope_adc_sequencer_unit.sv @@
// Dual-slope integrating voltmeter sequencer. One request per tick: a tick that does not
// end a conversion, or a start request, gives its result in the cycle after acceptance, and
// the next request is taken once that result has been taken. A tick that ends the
// deintegrate phase runs the count through a shared 32x32 multiplier, first by the gain
// and then by a reciprocal for the scale of one million: its result is registered after
// the ST_MUL_V and ST_SCALE_V states for a measurement, a zero calibration or a gain
// calibration with a zero reading. A gain calibration with a nonzero reading adds a
// multiply and a 32-step bit-serial division by that reading. Results carry the mux
// select lines and busy flag after the request.
// depends on dsas_pkg, dsas_div and dual_slope_adc_sequencer_unit_macros.svh
`include "dual_slope_adc_sequencer_unit_macros.svh"

module dual_slope_adc_sequencer_unit import dsas_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic                 i_comparator_high,
    input  logic [MV_W-1:0]      i_known_mv,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_mux_a0,
    output logic                 o_mux_a1,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [1:0]           o_done_kind,
    output logic [DATA_W-1:0]    o_reading_mv,
    output logic [RAW_W-1:0]     o_raw_count,
    output logic [1:0]           o_status
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FEEDBACK,
        PH_SETUP,
        PH_INTEGRATE,
        PH_DEINT
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_V,
        ST_SCALE_V,
        ST_MUL_G,
        ST_DIV_G
    } t_seq;

    // skip phases whose length is zero
    function automatic t_phase f_enter(t_phase p, logic [REG_W-1:0] fb,
                                       logic [REG_W-1:0] su, logic [REG_W-1:0] it);
        t_phase q;
        q = p;
        if (q == PH_FEEDBACK && fb == '0) q = PH_SETUP;
        if (q == PH_SETUP && su == '0) q = PH_INTEGRATE;
        if (q == PH_INTEGRATE && it == '0) q = PH_DEINT;
        return q;
    endfunction

    t_seq                  r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [1:0]            r_kind, n_kind;
    logic [REG_W-1:0]      r_timer, n_timer;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [RAW_W-1:0]      r_zero, n_zero;
    logic [DATA_W-1:0]     r_gain, n_gain;
    logic [MV_W-1:0]       r_target, n_target;
    logic [DATA_W-1:0]     r_vx, n_vx;
    logic                  r_over, n_over;
    logic [REG_W-1:0]      r_fb, r_su, r_it;

    logic                  r_out_valid, n_out_valid;
    logic                  r_a0, n_a0;
    logic                  r_a1, n_a1;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [1:0]            r_dkind, n_dkind;
    logic [DATA_W-1:0]     r_reading, n_reading;
    logic [RAW_W-1:0]      r_raw, n_raw;
    logic [1:0]            r_status, n_status;

    logic                  w_in_acc;
    logic [DATA_W-1:0]     w_mul_a, w_mul_b, w_mul_out;
    logic [PROD_W-1:0]     w_mul_full;
    logic [DATA_W-1:0]     w_scaled;
    logic                  w_div_start;
    logic [DATA_W-1:0]     w_div_divisor;
    t_div_stat             w_div_stat;
    logic [DATA_W-1:0]     w_quo;

    assign o_in_stall = (r_state != ST_IDLE) || r_out_valid;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_mul_full = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_mul_out  = w_mul_full[DATA_W-1:0];
    assign w_scaled   = DATA_W'(w_mul_full[PROD_W-1:RECIP_SHIFT]);

    dsas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mul_out),
        .i_divisor  (w_div_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    always_comb begin
        logic [REG_W:0] v_tmr;
        logic           v_fin;
        logic           v_over;
        logic [1:0]     v_stat;

        n_state     = r_state;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_timer     = r_timer;
        n_count     = r_count;
        n_zero      = r_zero;
        n_gain      = r_gain;
        n_target    = r_target;
        n_vx        = r_vx;
        n_over      = r_over;
        n_out_valid = r_out_valid && i_out_stall;
        n_a0        = r_a0;
        n_a1        = r_a1;
        n_busy      = r_busy;
        n_done      = r_done;
        n_dkind     = r_dkind;
        n_reading   = r_reading;
        n_raw       = r_raw;
        n_status    = r_status;

        w_mul_a       = DATA_W'(r_count) - DATA_W'(r_zero);
        w_mul_b       = r_gain;
        w_div_start   = 1'b0;
        w_div_divisor = r_vx;

        v_tmr  = {1'b0, r_timer} + 1'b1;
        v_fin  = 1'b0;
        v_over = 1'b0;
        v_stat = STAT_OK;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_mode != MODE_TICK) begin
                        if (r_phase != PH_IDLE) begin
                            v_stat = STAT_BUSY;
                        end else begin
                            case (i_mode)
                                MODE_MEAS: n_kind = KIND_MEAS;
                                MODE_ZERO: n_kind = KIND_ZERO;
                                default:   n_kind = KIND_GAIN;
                            endcase
                            if (i_mode == MODE_GAIN) n_target = i_known_mv;
                            n_count = '0;
                            n_timer = '0;
                            n_phase = f_enter(PH_FEEDBACK, r_fb, r_su, r_it);
                        end
                    end else begin
                        unique case (r_phase)
                            PH_IDLE: begin
                            end
                            PH_FEEDBACK: begin
                                n_timer = v_tmr[REG_W-1:0];
                                if (v_tmr >= {1'b0, r_fb}) begin
                                    n_timer = '0;
                                    n_phase = f_enter(PH_SETUP, r_fb, r_su, r_it);
                                end
                            end
                            PH_SETUP: begin
                                n_timer = v_tmr[REG_W-1:0];
                                if (v_tmr >= {1'b0, r_su}) begin
                                    n_timer = '0;
                                    n_phase = f_enter(PH_INTEGRATE, r_fb, r_su, r_it);
                                end
                            end
                            PH_INTEGRATE: begin
                                n_timer = v_tmr[REG_W-1:0];
                                if (v_tmr >= {1'b0, r_it}) begin
                                    n_timer = '0;
                                    n_phase = PH_DEINT;
                                end
                            end
                            PH_DEINT: begin
                                if (!i_comparator_high) begin
                                    v_fin = 1'b1;
                                end else begin
                                    if (r_count < COUNT_MAX) n_count = r_count + 1'b1;
                                    if (n_count == COUNT_MAX) begin
                                        v_fin  = 1'b1;
                                        v_over = 1'b1;
                                    end
                                end
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end

                    // count restarts on entry to deintegrate
                    if (n_phase == PH_DEINT && r_phase != PH_DEINT) n_count = '0;

                    if (v_fin) begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                        n_over  = v_over;
                        n_state = ST_MUL_V;
                    end else begin
                        n_out_valid = 1'b1;
                        unique case (n_phase)
                            PH_FEEDBACK: {n_a0, n_a1} = 2'b11;
                            PH_SETUP:    {n_a0, n_a1} = 2'b10;
                            PH_INTEGRATE: begin
                                n_a0 = 1'b0;
                                n_a1 = (n_kind == KIND_ZERO);
                            end
                            PH_DEINT:    {n_a0, n_a1} = 2'b10;
                            default:     {n_a0, n_a1} = 2'b00;
                        endcase
                        n_busy    = (n_phase != PH_IDLE);
                        n_done    = 1'b0;
                        n_dkind   = KIND_MEAS;
                        n_reading = '0;
                        n_raw     = '0;
                        n_status  = v_stat;
                    end
                end
            end
            ST_MUL_V: begin
                // (count - zero) * gain, wrapped to 32 bits
                n_vx    = w_mul_out;
                n_state = ST_SCALE_V;
            end
            ST_SCALE_V: begin
                // divide by one million through the reciprocal
                w_mul_a = r_vx >> RECIP_PRE;
                w_mul_b = RECIP_M;
                n_vx    = w_scaled;
                if (r_kind == KIND_GAIN && w_scaled != '0) begin
                    n_state = ST_MUL_G;
                end else begin
                    if (r_kind == KIND_ZERO) n_zero = RAW_W'(r_count);
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    {n_a0, n_a1} = 2'b00;
                    n_busy      = 1'b0;
                    n_done      = 1'b1;
                    n_dkind     = r_kind;
                    n_reading   = w_scaled;
                    n_raw       = RAW_W'(r_count);
                    if (r_kind == KIND_GAIN) n_status = STAT_DIV_ZERO;
                    else n_status = r_over ? STAT_OVER : STAT_OK;
                end
            end
            ST_MUL_G: begin
                w_mul_a     = r_gain;
                w_mul_b     = DATA_W'(r_target);
                w_div_start = 1'b1;
                n_state     = ST_DIV_G;
            end
            ST_DIV_G: begin
                if (w_div_stat.done) begin
                    n_gain      = w_quo;
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    {n_a0, n_a1} = 2'b00;
                    n_busy      = 1'b0;
                    n_done      = 1'b1;
                    n_dkind     = r_kind;
                    n_reading   = r_vx;
                    n_raw       = RAW_W'(r_count);
                    n_status    = r_over ? STAT_OVER : STAT_OK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_kind      <= KIND_MEAS;
            r_timer     <= '0;
            r_count     <= '0;
            r_zero      <= '0;
            r_gain      <= GAIN_RESET;
            r_target    <= '0;
            r_vx        <= '0;
            r_over      <= 1'b0;
            r_fb        <= FEEDBACK_RESET;
            r_su        <= SETUP_RESET;
            r_it        <= INTEGRATE_RESET;
            r_out_valid <= 1'b0;
            r_a0        <= 1'b0;
            r_a1        <= 1'b0;
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_dkind     <= KIND_MEAS;
            r_reading   <= '0;
            r_raw       <= '0;
            r_status    <= STAT_OK;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_timer     <= n_timer;
            r_count     <= n_count;
            r_zero      <= n_zero;
            r_gain      <= n_gain;
            r_target    <= n_target;
            r_vx        <= n_vx;
            r_over      <= n_over;
            r_out_valid <= n_out_valid;
            r_a0        <= n_a0;
            r_a1        <= n_a1;
            r_busy      <= n_busy;
            r_done      <= n_done;
            r_dkind     <= n_dkind;
            r_reading   <= n_reading;
            r_raw       <= n_raw;
            r_status    <= n_status;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FEEDBACK:  r_fb <= i_cfg_data;
                    CFG_SETUP:     r_su <= i_cfg_data;
                    CFG_INTEGRATE: r_it <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mux_a0     = r_a0;
    assign o_mux_a1     = r_a1;
    assign o_busy_res   = r_busy;
    assign o_done_res   = r_done;
    assign o_done_kind  = r_dkind;
    assign o_reading_mv = r_reading;
    assign o_raw_count  = r_raw;
    assign o_status     = r_status;

    `DSAS_ASSERT_NEXT(a_div_started, i_clk, i_rst_n, r_state == ST_MUL_G, w_div_stat.busy, "divider not started after multiply")
    `DSAS_ASSERT_IMPLY(a_no_overlap, i_clk, i_rst_n, r_state != ST_IDLE, !r_out_valid, "result pending while computing")
    `DSAS_ASSERT_IMPLY(a_div_zero_kind, i_clk, i_rst_n, o_out_valid && o_status == STAT_DIV_ZERO, o_done_kind == KIND_GAIN && o_reading_mv == '0, "zero divisor flag on wrong result")
    `DSAS_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res && !o_mux_a0 && !o_mux_a1, "finished result not idle")

endmodule

@@ sim/dual_slope_adc_sequencer_unit_tb.sv @@
// self-checking testbench for the dual-slope adc sequencer: drives start and tick requests,
// predicts every result with a cycle-free model of the conversion and compares field by field
// depends on dsas_pkg and the dual_slope_adc_sequencer_unit rtl
module dual_slope_adc_sequencer_unit_tb;
    import dsas_pkg::*;

    localparam int unsigned IDLE_LIMIT = 20000;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_FEEDBACK,
        SEQ_SETUP,
        SEQ_INTEGRATE,
        SEQ_DEINT
    } t_seq_phase;

    typedef struct packed {
        logic              mux_a0;
        logic              mux_a1;
        logic              busy;
        logic              done;
        logic [1:0]        kind;
        logic [DATA_W-1:0] reading;
        logic [RAW_W-1:0]  raw;
        logic [1:0]        status;
    } t_adc_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [REG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_mode;
    logic                 i_comparator_high;
    logic [MV_W-1:0]      i_known_mv;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_mux_a0;
    logic                 o_mux_a1;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic [1:0]           o_done_kind;
    logic [DATA_W-1:0]    o_reading_mv;
    logic [RAW_W-1:0]     o_raw_count;
    logic [1:0]           o_status;

    // predictor state and its copy of the registers
    logic [REG_W-1:0]      cfg_feedback;
    logic [REG_W-1:0]      cfg_setup;
    logic [REG_W-1:0]      cfg_integrate;
    t_seq_phase            seq_phase;
    logic [1:0]            seq_kind;
    int unsigned           phase_ticks;
    logic [COUNT_BITS-1:0] deint_count;
    logic [RAW_W-1:0]      zero_ofs;
    logic [DATA_W-1:0]     gain_k;
    logic [MV_W-1:0]       target_mv_q;

    t_adc_result pending_results[$];
    logic [1:0]  start_modes[3] = '{MODE_MEAS, MODE_ZERO, MODE_GAIN};

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned req_count         = 0;
    int unsigned results_checked   = 0;
    int unsigned conversions_seen  = 0;
    int unsigned error_count       = 0;
    int unsigned quiet_cycles      = 0;

    dual_slope_adc_sequencer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_comparator_high (i_comparator_high),
        .i_known_mv        (i_known_mv),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_mux_a0          (o_mux_a0),
        .o_mux_a1          (o_mux_a1),
        .o_busy_res        (o_busy_res),
        .o_done_res        (o_done_res),
        .o_done_kind       (o_done_kind),
        .o_reading_mv      (o_reading_mv),
        .o_raw_count       (o_raw_count),
        .o_status          (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [DATA_W-1:0] count_to_mv(input logic [COUNT_BITS-1:0] count);
        logic [DATA_W-1:0] diff;
        logic [DATA_W-1:0] prod;
        diff = DATA_W'(count) - DATA_W'(zero_ofs);
        prod = diff * gain_k;
        return prod / SCALE_DIV;
    endfunction

    // phases whose register is zero are skipped on entry
    function automatic void enter_phase(input t_seq_phase p);
        phase_ticks = 0;
        if (p == SEQ_FEEDBACK && cfg_feedback == 0) p = SEQ_SETUP;
        if (p == SEQ_SETUP && cfg_setup == 0) p = SEQ_INTEGRATE;
        if (p == SEQ_INTEGRATE && cfg_integrate == 0) p = SEQ_DEINT;
        if (p == SEQ_DEINT) deint_count = '0;
        seq_phase = p;
    endfunction

    function automatic void advance_sequencer(input logic [1:0] mode, input logic comp,
                                              input logic [MV_W-1:0] mv);
        t_adc_result       r;
        logic              finish;
        logic              over;
        logic [DATA_W-1:0] vx;
        logic [DATA_W-1:0] tgt;
        logic [DATA_W-1:0] prod;
        r      = '0;
        finish = 1'b0;
        over   = 1'b0;
        if (mode != MODE_TICK) begin
            if (seq_phase != SEQ_IDLE) begin
                r.status = STAT_BUSY;
            end else begin
                case (mode)
                    MODE_MEAS: seq_kind = KIND_MEAS;
                    MODE_ZERO: seq_kind = KIND_ZERO;
                    default: begin
                        seq_kind    = KIND_GAIN;
                        target_mv_q = mv;
                    end
                endcase
                deint_count = '0;
                enter_phase(SEQ_FEEDBACK);
            end
        end else begin
            case (seq_phase)
                SEQ_FEEDBACK: begin
                    phase_ticks++;
                    if (phase_ticks >= cfg_feedback) enter_phase(SEQ_SETUP);
                end
                SEQ_SETUP: begin
                    phase_ticks++;
                    if (phase_ticks >= cfg_setup) enter_phase(SEQ_INTEGRATE);
                end
                SEQ_INTEGRATE: begin
                    phase_ticks++;
                    if (phase_ticks >= cfg_integrate) enter_phase(SEQ_DEINT);
                end
                SEQ_DEINT: begin
                    if (!comp) begin
                        finish = 1'b1;
                    end else begin
                        if (deint_count < COUNT_MAX) deint_count++;
                        if (deint_count >= COUNT_MAX) begin
                            finish = 1'b1;
                            over   = 1'b1;
                        end
                    end
                end
                default: seq_phase = SEQ_IDLE;
            endcase
        end

        if (finish) begin
            vx        = count_to_mv(deint_count);
            r.done    = 1'b1;
            r.kind    = seq_kind;
            r.reading = vx;
            r.raw     = deint_count;
            r.status  = over ? STAT_OVER : STAT_OK;
            if (seq_kind == KIND_ZERO) begin
                zero_ofs = deint_count;
            end else if (seq_kind == KIND_GAIN) begin
                // a zero reading keeps the gain, even on a saturated count
                if (vx == 0) begin
                    r.status = STAT_DIV_ZERO;
                end else begin
                    tgt    = target_mv_q;
                    prod   = gain_k * tgt;
                    gain_k = prod / vx;
                end
            end
            seq_phase   = SEQ_IDLE;
            phase_ticks = 0;
        end

        case (seq_phase)
            SEQ_FEEDBACK:  {r.mux_a0, r.mux_a1} = 2'b11;
            SEQ_SETUP:     {r.mux_a0, r.mux_a1} = 2'b10;
            SEQ_INTEGRATE: {r.mux_a0, r.mux_a1} = {1'b0, seq_kind == KIND_ZERO};
            SEQ_DEINT:     {r.mux_a0, r.mux_a1} = 2'b10;
            default:       {r.mux_a0, r.mux_a1} = 2'b00;
        endcase
        r.busy = (seq_phase != SEQ_IDLE);
        pending_results.push_back(r);
    endfunction

    // ---------------------------------------------------------------- result check

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_adc_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with no request pending, expected none actual status %0h",
                         $time, o_status);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.done) conversions_seen++;
                compare_field("mux_a0", want.mux_a0, o_mux_a0);
                compare_field("mux_a1", want.mux_a1, o_mux_a1);
                compare_field("busy_res", want.busy, o_busy_res);
                compare_field("done_res", want.done, o_done_res);
                compare_field("done_kind", want.kind, o_done_kind);
                compare_field("reading_mv", want.reading, o_reading_mv);
                compare_field("raw_count", want.raw, o_raw_count);
                compare_field("status", want.status, o_status);
            end
        end
    end

    // counts cycles in which neither request, result nor register write moves
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || i_cfg_we || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // called at a falling edge with valid low; returns at the falling edge after acceptance, valid low
    task automatic send_request(input logic [1:0] mode, input logic comp,
                                input logic [MV_W-1:0] mv);
        while ($urandom_range(99) < sender_idle_pct) @(negedge i_clk);
        i_in_valid        = 1'b1;
        i_mode            = mode;
        i_comparator_high = comp;
        i_known_mv        = mv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_sequencer(mode, comp, mv);
        req_count++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_FEEDBACK:  cfg_feedback  = val;
            CFG_SETUP:     cfg_setup     = val;
            CFG_INTEGRATE: cfg_integrate = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_phase_lengths(input logic [REG_W-1:0] fb, input logic [REG_W-1:0] su,
                                     input logic [REG_W-1:0] it);
        wait_drained();
        write_config(CFG_FEEDBACK, fb);
        write_config(CFG_SETUP, su);
        write_config(CFG_INTEGRATE, it);
    endtask

    // one full conversion: start, the timed phases, deint_len high comparator ticks,
    // then a low one unless the count saturates; busy starts are sprinkled in
    task automatic run_conversion(input logic [1:0] start_mode, input logic [MV_W-1:0] target,
                                  input int unsigned deint_len, input int unsigned busy_pct);
        int unsigned lead;
        int unsigned total;
        int unsigned n;
        lead  = cfg_feedback + cfg_setup + cfg_integrate;
        total = lead + deint_len + ((deint_len < COUNT_MAX) ? 1 : 0);
        send_request(start_mode, 1'($urandom_range(1)), target);
        for (n = 0; n < total; n++) begin
            if ($urandom_range(99) < busy_pct)
                send_request(start_modes[$urandom_range(2)], 1'($urandom_range(1)),
                             MV_W'($urandom_range(16383)));
            send_request(MODE_TICK, (n < lead) ? 1'($urandom_range(1)) : (n < lead + deint_len),
                         MV_W'($urandom_range(16383)));
        end
    endtask

    task automatic run_random_conversion();
        logic [1:0]        start_mode;
        logic [MV_W-1:0]   target;
        logic [DATA_W-1:0] vx;
        logic [DATA_W-1:0] prod;
        logic [DATA_W-1:0] new_gain;
        int unsigned       deint_len;
        int unsigned       tries;
        start_mode = start_modes[$urandom_range(2)];
        target     = MV_W'($urandom_range(16383));
        deint_len  = ($urandom_range(9) == 0) ? $urandom_range(150) : $urandom_range(40);
        if (start_mode == MODE_GAIN) begin
            if ($urandom_range(9) == 0) begin
                deint_len = zero_ofs;
            end else begin
                // look for a calibration that keeps the gain usable, else measure instead
                start_mode = MODE_MEAS;
                for (tries = 0; tries < 64 && start_mode != MODE_GAIN; tries++) begin
                    deint_len = zero_ofs + $urandom_range(1, 300);
                    target    = MV_W'($urandom_range(1, 9999));
                    prod      = (deint_len - zero_ofs) * gain_k;
                    vx        = prod / SCALE_DIV;
                    prod      = gain_k * DATA_W'(target);
                    new_gain  = (vx == 0) ? '0 : prod / vx;
                    if (new_gain >= 20000 && new_gain <= 4000000) start_mode = MODE_GAIN;
                end
            end
        end
        run_conversion(start_mode, target, deint_len, 5);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_idle_ticks();
        send_request(MODE_TICK, 1'b0, '0);
        send_request(MODE_TICK, 1'b1, '1);
        send_request(MODE_TICK, 1'b0, 14'h2aaa);
        send_request(MODE_TICK, 1'b1, 14'h1555);
    endtask

    task automatic test_measure_sequence();
        set_phase_lengths(16'd2, 16'd1, 16'd3);
        write_config(CFG_IDX_W'(3), 16'hffff);    // unused index, must change nothing
        run_conversion(MODE_MEAS, '1, 10, 50);
    endtask

    task automatic test_zero_calibration();
        run_conversion(MODE_ZERO, '0, 5, 0);
    endtask

    // every phase length zero: the start goes straight to deintegrate; then only integrate is timed
    task automatic test_skipped_phases();
        set_phase_lengths('0, '0, '0);
        run_conversion(MODE_GAIN, 14'd20, 25, 0);
        set_phase_lengths('0, '0, 16'd3);
        run_conversion(MODE_ZERO, '0, 8, 0);
    endtask

    task automatic test_gain_zero_divisor();
        set_phase_lengths(16'd1, 16'd2, 16'd1);
        run_conversion(MODE_MEAS, '0, 3, 0);             // count below offset wraps
        run_conversion(MODE_GAIN, 14'd5000, zero_ofs, 0); // zero reading keeps the gain
        run_conversion(MODE_ZERO, '0, 0, 0);
        run_conversion(MODE_GAIN, 14'd1234, 0, 0);
        run_conversion(MODE_MEAS, '0, 60, 0);
    endtask

    task automatic test_random_traffic();
        int unsigned first_req;
        int unsigned leg;
        first_req = req_count;
        for (leg = 0; leg < 3; leg++) begin
            case (leg)
                0: begin sender_idle_pct = 33; receiver_idle_pct = 83; end
                1: begin sender_idle_pct = 83; receiver_idle_pct = 33; end
                default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            endcase
            while (req_count - first_req < (leg + 1) * 170) begin
                if ($urandom_range(5) == 0)
                    set_phase_lengths(REG_W'($urandom_range(6)), REG_W'($urandom_range(6)),
                                      ($urandom_range(9) == 0) ? '0
                                                               : REG_W'($urandom_range(1, 8)));
                else if ($urandom_range(7) == 0)
                    wait_drained();
                run_random_conversion();
                repeat ($urandom_range(2))
                    send_request(MODE_TICK, 1'($urandom_range(1)),
                                 MV_W'($urandom_range(16383)));
            end
        end
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
    endtask

    // a zero target drives the gain to zero, after which every reading is zero
    task automatic test_zero_target();
        run_conversion(MODE_GAIN, '0, zero_ofs + 50, 0);
        run_conversion(MODE_MEAS, '0, 20, 0);
        run_conversion(MODE_GAIN, 14'd777, zero_ofs + 30, 0);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_FEEDBACK;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_mode            = MODE_TICK;
        i_comparator_high = 1'b0;
        i_known_mv        = '0;
        cfg_feedback      = FEEDBACK_RESET;
        cfg_setup         = SETUP_RESET;
        cfg_integrate     = INTEGRATE_RESET;
        seq_phase         = SEQ_IDLE;
        seq_kind          = KIND_MEAS;
        phase_ticks       = 0;
        deint_count       = '0;
        zero_ofs          = '0;
        gain_k            = GAIN_RESET;
        target_mv_q       = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_ticks();
        test_measure_sequence();
        test_zero_calibration();
        test_skipped_phases();
        test_gain_zero_divisor();
        test_random_traffic();
        test_zero_target();

        wait_drained();
        repeat (100) @(negedge i_clk);
        $display("%0d requests sent, %0d conversions finished, incl. skipped phases,",
                 req_count, conversions_seen);
        $display("zero divisors, wrapped readings and busy starts; %0d results, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
